>>> rtl/core/hgpss_pkg.sv
// Shared types and constants for the GET path segment splitter.
`default_nettype none

package hgpss_pkg;

    // Line phases: 0..3 count matched characters of "GET ".
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_PATH  = 3'd4;
    localparam logic [2:0] PH_SKIP  = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Characters that steer the parser.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] segment_index;
        logic [7:0] path_byte;
        logic       overflow;
    } res_t;

    // Expected character of the request method word at a given position.
    function automatic logic [7:0] get_char(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0: ch = 8'h47;
            2'd1: ch = 8'h45;
            2'd2: ch = 8'h54;
            2'd3: ch = CH_SPACE;
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/http_get_path_segment_splitter_core.sv
// Top level of the GET request path segment splitter.
// Usage:
// The input channel (in_valid, in_ready, in_byte) takes raw HTTP header
// bytes, one item per handshake. Lines that start with "GET " have their
// request path split at each slash into numbered segments.
// The output channel (out_valid, out_ready, kind, segment_index, path_byte,
// overflow) gives at most one result item per input item: a segment start,
// a path byte tagged with its segment, or a path end carrying the overflow
// flag when more than MAX_SEGMENTS segments appeared.
// The accepting edge loads the input register, and the parse logic then
// writes the result register, which drives out_valid.
// Throughput is one item per cycle while the receiver does not stall, set
// by the parse step on the input register; bytes that give no result
// still pass through that step.
// When the receiver stalls, the result register holds its item and the input
// register holds the next byte; in_ready drops only when both are full.
// Reset clears both valid flags and returns the parser to line start with a
// zero segment count and no overflow seen.
`default_nettype none

module http_get_path_segment_splitter_core
    import hgpss_pkg::*;
#(
    parameter int MAX_SEGMENTS = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [2:0]      segment_index,
    output logic [7:0]      path_byte,
    output logic            overflow
);

    // The segment counter must be able to hold MAX_SEGMENTS itself.
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    // Input register.
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;

    // Parser state.
    logic [2:0]       phase_reg;
    logic [2:0]       phase_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;

    // Result register.
    logic             out_valid_reg;
    res_t             res_reg;
    logic             res_valid;
    res_t             res;

    logic             advance;

    // The parse step runs when the held byte has somewhere to put its result.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    hgpss_step #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .CNT_W        (CNT_W)
    ) u_step (
        .in_byte    (in_byte_reg),
        .phase      (phase_reg),
        .count      (count_reg),
        .ovf        (ovf_reg),
        .phase_next (phase_next),
        .count_next (count_next),
        .ovf_next   (ovf_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                ovf_reg       <= ovf_next;
                out_valid_reg <= res_valid;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = res_reg.kind;
    assign segment_index = res_reg.segment_index;
    assign path_byte     = res_reg.path_byte;
    assign overflow      = res_reg.overflow;

`ifndef NO_ASSERTIONS
    // The segment counter never runs past the configured limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count beyond limit");

    // Only path byte results carry a character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_BYTE) |-> (path_byte == 8'd0))
        else $error("path byte set on a non-byte result");

    // Only path end results carry the overflow flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_END) |-> !overflow)
        else $error("overflow set on a non-end result");

    // A result is only produced while inside a path.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid |-> (phase_reg == PH_PATH))
        else $error("result produced outside a path");
`endif

endmodule

`default_nettype wire

>>> rtl/core/hgpss_step.sv
// Per-byte parsing logic: next state and the optional result for one item.
`default_nettype none

module hgpss_step
    import hgpss_pkg::*;
#(
    parameter int MAX_SEGMENTS = 8,
    parameter int CNT_W        = 4
)
(
    input  wire logic [7:0]       in_byte,
    input  wire logic [2:0]       phase,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic             ovf,
    output logic [2:0]            phase_next,
    output logic [CNT_W-1:0]      count_next,
    output logic                  ovf_next,
    output logic                  res_valid,
    output res_t                  res
);

    localparam int EXT_W = CNT_W + 3;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    logic [EXT_W-1:0] cur_ext;
    logic [EXT_W-1:0] last_ext;
    logic             is_end;

    assign cur_ext  = EXT_W'(count);
    assign last_ext = (count != '0) ? EXT_W'(count - ONE_CNT) : '0;
    assign is_end   = (in_byte == CH_SPACE) || (in_byte == CH_CR) || (in_byte == CH_LF);

    always_comb
    begin
        phase_next = phase;
        count_next = count;
        ovf_next   = ovf;
        res_valid  = 1'b0;
        res        = '0;
        if (phase == PH_PATH)
        begin
            priority if (is_end)
            begin
                res_valid         = 1'b1;
                res.kind          = KIND_END;
                res.segment_index = last_ext[2:0];
                res.overflow      = ovf;
                phase_next        = (in_byte == CH_LF) ? PH_START : PH_SKIP;
            end
            else if (in_byte == CH_SLASH)
            begin
                if (count < MAX_CNT)
                begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_START;
                    res.segment_index = cur_ext[2:0];
                    count_next        = count + ONE_CNT;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                // Bytes before the first slash and in dropped segments give nothing.
                if ((count != '0) && !ovf)
                begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_BYTE;
                    res.segment_index = last_ext[2:0];
                    res.path_byte     = in_byte;
                end
            end
        end
        else
        begin
            priority if (in_byte == CH_LF)
            begin
                phase_next = PH_START;
            end
            else if (phase < PH_PATH)
            begin
                if (in_byte == get_char(phase[1:0]))
                begin
                    phase_next = phase + 3'd1;
                    if (phase_next == PH_PATH)
                    begin
                        // A new request starts with a clean segment count.
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
            else
            begin
                phase_next = PH_SKIP;
            end
        end
    end

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the GET request path segment splitter.
`timescale 1ns / 100ps

module tb;
    import hgpss_pkg::*;

    localparam int MAX_SEGMENTS = 8;
    localparam int TOTAL_ITEMS  = 1250;   // minimum number of input items in the run
    localparam int HOLD_CYCLES  = 150;    // long receiver stall
    localparam int HOLD_AT      = 400;    // items accepted before the stall begins
    localparam int QUIET_FROM   = 700;    // window in which neither side idles
    localparam int QUIET_TO     = 1100;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [31:0] GET_WORD = "GET ";

    // One row of stimulus. Fixed rows carry a typed expectation; the others
    // are checked against the predictor.
    typedef struct {
        logic [7:0] data;
        bit         fixed;
        bit         has_res;
        res_t       res;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] kind;
    logic [2:0] segment_index;
    logic [7:0] path_byte;
    logic       overflow;

    stim_row_t stim_rows[$];
    res_t      pending_results[$];

    // Predictor state.
    logic [2:0]  scan_phase;
    int unsigned seg_open;
    bit          seg_dropped;

    int  accepted_n;
    int  useful_bytes;
    int  errors;
    int  cycles;
    int  n_start;
    int  n_path;
    int  n_end;
    int  n_ovf_end;
    bit  hold_done;

    http_get_path_segment_splitter_core #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .segment_index(segment_index),
        .path_byte    (path_byte),
        .overflow     (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Advances the predicted parser by one header byte. Returns 1 when the
    // byte produces a result item, which is placed in r.
    function automatic bit split_step(input logic [7:0] c, output res_t r);
        int pos;
        r = '0;
        if (scan_phase == PH_PATH)
        begin
            if (c == CH_SPACE || c == CH_CR || c == CH_LF)
            begin
                r.kind          = KIND_END;
                r.segment_index = (seg_open > 0) ? 3'(seg_open - 1) : 3'd0;
                r.overflow      = seg_dropped;
                scan_phase      = (c == CH_LF) ? PH_START : PH_SKIP;
                return 1'b1;
            end
            if (c == CH_SLASH)
            begin
                if (seg_open < MAX_SEGMENTS)
                begin
                    r.kind          = KIND_START;
                    r.segment_index = 3'(seg_open);
                    seg_open++;
                    return 1'b1;
                end
                seg_dropped = 1'b1;
                return 1'b0;
            end
            // Bytes before the first slash, and in dropped segments, vanish.
            if (seg_open == 0 || seg_dropped)
                return 1'b0;
            r.kind          = KIND_BYTE;
            r.segment_index = 3'(seg_open - 1);
            r.path_byte     = c;
            return 1'b1;
        end
        if (c == CH_LF)
        begin
            scan_phase = PH_START;
            return 1'b0;
        end
        if (scan_phase < PH_PATH)
        begin
            pos = int'(scan_phase);
            if (c == GET_WORD[8 * (3 - pos) +: 8])
            begin
                scan_phase = scan_phase + 3'd1;
                if (scan_phase == PH_PATH)
                begin
                    seg_open    = 0;
                    seg_dropped = 1'b0;
                end
            end
            else
                scan_phase = PH_SKIP;
            return 1'b0;
        end
        scan_phase = PH_SKIP;
        return 1'b0;
    endfunction

    function automatic stim_row_t fixed_row(input logic [7:0] data, input bit has_res,
                                            input logic [1:0] k, input logic [2:0] idx,
                                            input logic [7:0] pb, input logic ovf);
        stim_row_t row;
        row.data                = data;
        row.fixed               = 1'b1;
        row.has_res             = has_res;
        row.res.kind            = k;
        row.res.segment_index   = idx;
        row.res.path_byte       = pb;
        row.res.overflow        = ovf;
        return row;
    endfunction

    function automatic stim_row_t free_row(input logic [7:0] data);
        stim_row_t row;
        row.data    = data;
        row.fixed   = 1'b0;
        row.has_res = 1'b0;
        row.res     = '0;
        return row;
    endfunction

    // A byte that stays inside the path: mostly printable, sometimes any value.
    function automatic logic [7:0] path_char();
        logic [7:0] c;
        if ($urandom_range(99) < 80)
            c = 8'($urandom_range(8'h7E, 8'h21));
        else
            c = 8'($urandom_range(255, 0));
        if (c == CH_SLASH || c == CH_SPACE || c == CH_CR || c == CH_LF)
            c = 8'h5F;
        return c;
    endfunction

    // Appends one random line. Most are well-formed requests with random
    // paths; the rest are broken method words and plain noise.
    task automatic add_random_line();
        int sel;
        int nseg;
        int k;
        logic [7:0] c;
        sel = $urandom_range(99);
        if (sel < 75)
        begin
            for (int i = 0; i < 4; i++)
                stim_rows.push_back(free_row(GET_WORD[8 * (3 - i) +: 8]));
            if ($urandom_range(99) < 20)
            begin
                k = $urandom_range(3, 1);
                for (int i = 0; i < k; i++)
                begin
                    stim_rows.push_back(free_row(path_char()));
                    useful_bytes++;
                end
            end
            sel = $urandom_range(99);
            nseg = (sel < 70) ? $urandom_range(5, 0) :
                   (sel < 90) ? $urandom_range(8, 6) : $urandom_range(12, 9);
            for (int s = 0; s < nseg; s++)
            begin
                stim_rows.push_back(free_row(CH_SLASH));
                useful_bytes++;
                k = $urandom_range(4, 0);
                for (int i = 0; i < k; i++)
                begin
                    stim_rows.push_back(free_row(path_char()));
                    useful_bytes++;
                end
            end
            sel = $urandom_range(99);
            c = (sel < 50) ? CH_SPACE : (sel < 75) ? CH_CR : CH_LF;
            stim_rows.push_back(free_row(c));
            useful_bytes++;
            if (c != CH_LF)
            begin
                // The rest of the line is ignored, even another method word.
                k = $urandom_range(5, 0);
                for (int i = 0; i < k; i++)
                begin
                    c = ($urandom_range(99) < 10) ? 8'($urandom_range(255, 0))
                                                  : path_char();
                    if (c == CH_LF)
                        c = 8'h41;
                    stim_rows.push_back(free_row(c));
                end
                if ($urandom_range(99) < 80)
                    stim_rows.push_back(free_row(CH_CR));
                stim_rows.push_back(free_row(CH_LF));
            end
        end
        else if (sel < 88)
        begin
            // Method word broken after a few matching characters.
            k = $urandom_range(3, 0);
            for (int i = 0; i < k; i++)
                stim_rows.push_back(free_row(GET_WORD[8 * (3 - i) +: 8]));
            c = 8'($urandom_range(255, 0));
            if (c == GET_WORD[8 * (3 - k) +: 8] || c == CH_LF)
                c = 8'h2F;
            stim_rows.push_back(free_row(c));
            k = $urandom_range(6, 0);
            for (int i = 0; i < k; i++)
                stim_rows.push_back(free_row(path_char()));
            stim_rows.push_back(free_row(CH_LF));
        end
        else
        begin
            // Raw noise, which may hold line feeds of its own.
            k = $urandom_range(12, 1);
            for (int i = 0; i < k; i++)
                stim_rows.push_back(free_row(8'($urandom_range(255, 0))));
            stim_rows.push_back(free_row(CH_LF));
        end
    endtask

    function automatic bit quiet_window();
        return accepted_n >= QUIET_FROM && accepted_n < QUIET_TO;
    endfunction

    // Input and output monitor: predicts on each accepted item and checks
    // each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        res_t predicted;
        res_t want;
        bit   has;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                has = split_step(in_byte, predicted);
                if (stim_rows[accepted_n].fixed)
                begin
                    if (stim_rows[accepted_n].has_res)
                        pending_results.push_back(stim_rows[accepted_n].res);
                end
                else if (has)
                    pending_results.push_back(predicted);
                accepted_n++;
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: kind %0d, segment %0d, byte %02h, ovf %0d",
                             $time, kind, segment_index, path_byte, overflow);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind)
                    begin
                        $display("%0t: kind: expected %0d, actual %0d",
                                 $time, want.kind, kind);
                        errors++;
                    end
                    if (segment_index !== want.segment_index)
                    begin
                        $display("%0t: segment_index: expected %0d, actual %0d",
                                 $time, want.segment_index, segment_index);
                        errors++;
                    end
                    if (path_byte !== want.path_byte)
                    begin
                        $display("%0t: path_byte: expected %02h, actual %02h",
                                 $time, want.path_byte, path_byte);
                        errors++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $display("%0t: overflow: expected %0d, actual %0d",
                                 $time, want.overflow, overflow);
                        errors++;
                    end
                    case (want.kind)
                        KIND_START: n_start++;
                        KIND_BYTE:  n_path++;
                        default:
                        begin
                            n_end++;
                            if (want.overflow)
                                n_ovf_end++;
                        end
                    endcase
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, one long hold-off so that the input and
    // result registers fill and in_ready drops, and a stretch with no stalls.
    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && accepted_n >= HOLD_AT)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            out_ready <= quiet_window() ? 1'b1 : ($urandom_range(99) >= 9);
        end
    end

    // Sender and run control.
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_byte      = 8'h00;
        scan_phase   = PH_START;
        seg_open     = 0;
        seg_dropped  = 1'b0;
        accepted_n   = 0;
        useful_bytes = 0;
        errors       = 0;
        cycles       = 0;
        n_start      = 0;
        n_path       = 0;
        n_end        = 0;
        n_ovf_end    = 0;

        // Directed part: a request with a byte before the first slash,
        // extreme byte values, too many segments ended by a CR, then an empty
        // path ended by a line feed and a line that is not a request.
        stim_rows.push_back(fixed_row("G", 0, KIND_START, 0, 0, 0));
        stim_rows.push_back(fixed_row("E", 0, KIND_START, 0, 0, 0));
        stim_rows.push_back(fixed_row("T", 0, KIND_START, 0, 0, 0));
        stim_rows.push_back(fixed_row(CH_SPACE, 0, KIND_START, 0, 0, 0));
        stim_rows.push_back(fixed_row("q", 0, KIND_START, 0, 0, 0));
        stim_rows.push_back(fixed_row(CH_SLASH, 1, KIND_START, 0, 0, 0));
        stim_rows.push_back(fixed_row(8'hFF, 1, KIND_BYTE, 0, 8'hFF, 0));
        stim_rows.push_back(fixed_row(8'h00, 1, KIND_BYTE, 0, 8'h00, 0));
        for (int i = 0; i < MAX_SEGMENTS - 1; i++)
            stim_rows.push_back(free_row(CH_SLASH));
        stim_rows.push_back(fixed_row(CH_SLASH, 0, KIND_START, 0, 0, 0));
        stim_rows.push_back(fixed_row("k", 0, KIND_START, 0, 0, 0));
        stim_rows.push_back(fixed_row(CH_CR, 1, KIND_END, 3'(MAX_SEGMENTS - 1), 0, 1));
        stim_rows.push_back(fixed_row(CH_LF, 0, KIND_START, 0, 0, 0));
        stim_rows.push_back(free_row("G"));
        stim_rows.push_back(free_row("E"));
        stim_rows.push_back(free_row("T"));
        stim_rows.push_back(free_row(CH_SPACE));
        stim_rows.push_back(fixed_row(CH_LF, 1, KIND_END, 0, 0, 0));
        stim_rows.push_back(fixed_row("X", 0, KIND_START, 0, 0, 0));
        stim_rows.push_back(fixed_row("G", 0, KIND_START, 0, 0, 0));
        stim_rows.push_back(fixed_row(CH_LF, 0, KIND_START, 0, 0, 0));

        while (stim_rows.size() < TOTAL_ITEMS)
            add_random_line();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
        begin
            while (!quiet_window() && $urandom_range(99) < 9)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_byte  <= stim_rows[i].data;
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            @(negedge clk);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes (%0d on paths) in %0d cycles, one %0d-cycle output stall.",
                 accepted_n, useful_bytes, cycles, HOLD_CYCLES);
        $display("Checked %0d segment starts, %0d path bytes, %0d path ends (%0d overflowed).",
                 n_start, n_path, n_end, n_ovf_end);
        if (errors == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
